// ===== src/wsd_pkg.sv =====
// Shared types and constants for the WAV stream deframer.
// Used by the parser, the result queue, the top level and the checker.
package wsd_pkg;

	localparam int unsigned QUEUE_DEPTH = 4;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_FORMAT = 2'd1;
	localparam logic [1:0] ST_TRUNC  = 2'd2;

	localparam logic [31:0] ID_DATA      = 32'h6461_7461;
	localparam logic [31:0] POS_CHAN_LO  = 32'd22;
	localparam logic [31:0] POS_CHAN_HI  = 32'd23;
	localparam logic [31:0] POS_RATE_LO  = 32'd24;
	localparam logic [31:0] POS_RATE_END = 32'd28;
	localparam logic [31:0] POS_BITS_LO  = 32'd34;
	localparam logic [31:0] POS_BITS_HI  = 32'd35;
	localparam logic [31:0] POS_RIFF_END = 32'd4;
	localparam logic [31:0] POS_WAVE_LO  = 32'd8;
	localparam logic [31:0] POS_WAVE_END = 32'd12;
	localparam logic [15:0] PCM_BITS     = 16'd16;
	localparam logic [32:0] CHUNK_HDR_LEN = 33'd8;

	typedef enum logic [5:0] {
		PH_HEADER = 6'b000001,
		PH_CHUNK  = 6'b000010,
		PH_SKIP   = 6'b000100,
		PH_DATA   = 6'b001000,
		PH_DONE   = 6'b010000,
		PH_EMPTY  = 6'b100000
	} phase_t;

	typedef struct packed {
		logic               is_sample;
		logic signed [16:0] pcm_sample;
		logic [31:0]        rate_hz;
		logic [1:0]         status;
		logic               last_of_run;
	} result_t;

	function automatic logic [7:0] riff_char(input logic [1:0] idx);
		case (idx)
			2'd0:    riff_char = 8'h52;
			2'd1:    riff_char = 8'h49;
			default: riff_char = 8'h46;
		endcase
	endfunction

	function automatic logic [7:0] wave_char(input logic [1:0] idx);
		case (idx)
			2'd0:    wave_char = 8'h57;
			2'd1:    wave_char = 8'h41;
			2'd2:    wave_char = 8'h56;
			default: wave_char = 8'h45;
		endcase
	endfunction

endpackage

// ===== src/wsd_parser.sv =====
// Input register and per-byte parser state: header checks, chunk walk, sample forming.
// Depends on wsd_pkg; emits up to two results per byte toward the result queue.
module wsd_parser (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [7:0]       stream_byte,
	input  logic             end_of_stream,
	input  logic             raw_mode,
	input  logic             room,
	output wsd_pkg::result_t res0,
	output wsd_pkg::result_t res1,
	output logic [1:0]       res_cnt
);
	import wsd_pkg::*;

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        eos_s1;
	logic        step;

	logic [31:0] pos_q, pos_d;
	phase_t      phase_q, phase_d;
	logic        hdr_ok_q, hdr_ok_d;
	logic [15:0] chan_q, chan_d;
	logic [15:0] bits_q, bits_d;
	logic [31:0] rate_q, rate_d;
	logic [63:0] chb_q, chb_d;
	logic [32:0] rem_q, rem_d;
	logic [7:0]  low_q, low_d;
	logic [15:0] left_q, left_d;
	logic [31:0] dsize_q, dsize_d;

	logic [15:0]        word;
	logic [1:0]         idx_lo;
	logic [63:0]        chb_sh;
	logic [32:0]        rem_inc;
	logic [32:0]        rem_dec;
	logic [31:0]        size;
	logic               fmt_ok_q;
	logic               fmt_ok_d;
	logic [31:0]        rate_out;
	logic               samp_v;
	logic signed [16:0] samp_val;
	logic [1:0]         st;
	result_t            samp_res;
	result_t            stat_res;

	assign step     = valid_s1 && room;
	assign in_ready = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= stream_byte;
			eos_s1  <= end_of_stream;
		end
	end

	assign word     = {byte_s1, low_q};
	assign idx_lo   = dsize_q[1:0] - rem_q[1:0];
	assign chb_sh   = {chb_q[55:0], byte_s1};
	assign rem_inc  = rem_q + 33'd1;
	assign rem_dec  = rem_q - 33'd1;
	assign size     = {chb_sh[7:0], chb_sh[15:8], chb_sh[23:16], chb_sh[31:24]};
	assign fmt_ok_q = hdr_ok_q && bits_q == PCM_BITS && (chan_q == 16'd1 || chan_q == 16'd2);
	assign fmt_ok_d = hdr_ok_d && bits_d == PCM_BITS && (chan_d == 16'd1 || chan_d == 16'd2);
	assign rate_out = raw_mode ? 32'd0 : rate_q;

	always_comb begin
		pos_d    = pos_q + 32'd1;
		phase_d  = phase_q;
		hdr_ok_d = hdr_ok_q;
		chan_d   = chan_q;
		bits_d   = bits_q;
		rate_d   = rate_q;
		chb_d    = chb_q;
		rem_d    = rem_q;
		low_d    = low_q;
		left_d   = left_q;
		dsize_d  = dsize_q;
		samp_v   = 1'b0;
		samp_val = '0;
		if (raw_mode) begin
			if (pos_q[0]) begin
				samp_v   = 1'b1;
				samp_val = {word, 1'b0};
			end else begin
				low_d = byte_s1;
			end
		end else begin
			unique case (phase_q)
				PH_HEADER: begin
					if (pos_q < POS_RIFF_END && byte_s1 != riff_char(pos_q[1:0]))
						hdr_ok_d = 1'b0;
					if (pos_q >= POS_WAVE_LO && pos_q < POS_WAVE_END
							&& byte_s1 != wave_char(pos_q[1:0]))
						hdr_ok_d = 1'b0;
					if (pos_q == POS_CHAN_LO) chan_d[7:0]  = byte_s1;
					if (pos_q == POS_CHAN_HI) chan_d[15:8] = byte_s1;
					if (pos_q >= POS_RATE_LO && pos_q < POS_RATE_END) begin
						case (pos_q[1:0])
							2'd0:    rate_d[7:0]   = byte_s1;
							2'd1:    rate_d[15:8]  = byte_s1;
							2'd2:    rate_d[23:16] = byte_s1;
							default: rate_d[31:24] = byte_s1;
						endcase
					end
					if (pos_q == POS_BITS_LO) bits_d[7:0] = byte_s1;
					if (pos_q == POS_BITS_HI) begin
						bits_d[15:8] = byte_s1;
						phase_d      = PH_CHUNK;
						rem_d        = '0;
					end
				end
				PH_CHUNK: begin
					chb_d = chb_sh;
					rem_d = rem_inc;
					if (rem_inc >= CHUNK_HDR_LEN) begin
						if (chb_sh[63:32] == ID_DATA) begin
							dsize_d = size;
							rem_d   = {1'b0, size};
							phase_d = (size != '0) ? PH_DATA : PH_EMPTY;
						end else begin
							rem_d   = {1'b0, size} + {32'd0, size[0]};
							phase_d = (size != '0) ? PH_SKIP : PH_CHUNK;
						end
					end
				end
				PH_SKIP: begin
					rem_d = rem_dec;
					if (rem_dec == '0) phase_d = PH_CHUNK;
				end
				PH_DATA: begin
					rem_d = rem_dec;
					if (rem_dec == '0) phase_d = PH_DONE;
					if (!idx_lo[0]) begin
						low_d = byte_s1;
					end else if (fmt_ok_q) begin
						if (chan_q == 16'd1) begin
							samp_v   = 1'b1;
							samp_val = {word, 1'b0};
						end else if (!idx_lo[1]) begin
							left_d = word;
						end else begin
							samp_v   = 1'b1;
							samp_val = {left_q[15], left_q} + {word[15], word};
						end
					end
				end
				PH_DONE, PH_EMPTY: begin
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		if (raw_mode)
			st = ST_OK;
		else if (phase_d == PH_DONE && fmt_ok_d)
			st = ST_OK;
		else if (phase_d == PH_DATA && fmt_ok_d)
			st = ST_TRUNC;
		else
			st = ST_FORMAT;
	end

	always_comb begin
		samp_res             = '0;
		samp_res.is_sample   = 1'b1;
		samp_res.pcm_sample  = samp_val;
		samp_res.rate_hz     = rate_out;
		samp_res.last_of_run = !eos_s1;
		stat_res             = '0;
		stat_res.rate_hz     = rate_out;
		stat_res.status      = st;
		stat_res.last_of_run = 1'b1;
		res0                 = samp_v ? samp_res : stat_res;
		res1                 = stat_res;
		if (!step)
			res_cnt = 2'd0;
		else
			res_cnt = {1'b0, samp_v} + {1'b0, eos_s1};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			phase_q  <= PH_HEADER;
			hdr_ok_q <= 1'b1;
			chan_q   <= '0;
			bits_q   <= '0;
			rate_q   <= '0;
			chb_q    <= '0;
			rem_q    <= '0;
			low_q    <= '0;
			left_q   <= '0;
			dsize_q  <= '0;
		end else if (step) begin
			if (eos_s1) begin
				pos_q    <= '0;
				phase_q  <= PH_HEADER;
				hdr_ok_q <= 1'b1;
				chan_q   <= '0;
				bits_q   <= '0;
				rate_q   <= '0;
				chb_q    <= '0;
				rem_q    <= '0;
				low_q    <= '0;
				left_q   <= '0;
				dsize_q  <= '0;
			end else begin
				pos_q    <= pos_d;
				phase_q  <= phase_d;
				hdr_ok_q <= hdr_ok_d;
				chan_q   <= chan_d;
				bits_q   <= bits_d;
				rate_q   <= rate_d;
				chb_q    <= chb_d;
				rem_q    <= rem_d;
				low_q    <= low_d;
				left_q   <= left_d;
				dsize_q  <= dsize_d;
			end
		end
	end

endmodule

// ===== src/wsd_result_queue.sv =====
// Small result queue: takes up to two results per cycle, hands out one per transfer.
// Depends on wsd_pkg for the result record.
module wsd_result_queue #(
	parameter int unsigned Depth = wsd_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  wsd_pkg::result_t wr0,
	input  wsd_pkg::result_t wr1,
	input  logic [1:0]       wr_cnt,
	output logic             room,
	output logic             out_valid,
	input  logic             out_ready,
	output wsd_pkg::result_t rd
);
	import wsd_pkg::*;

	localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int unsigned CntW = $clog2(Depth + 1);

	result_t           mem_q [Depth];
	logic [PtrW-1:0]   wr_ptr_q;
	logic [PtrW-1:0]   rd_ptr_q;
	logic [CntW-1:0]   cnt_q;
	logic [PtrW-1:0]   wr_ptr1;
	logic              pop;

	function automatic logic [PtrW-1:0] inc(input logic [PtrW-1:0] p);
		inc = (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
	endfunction

	assign wr_ptr1   = inc(wr_ptr_q);
	assign out_valid = cnt_q != '0;
	assign pop       = out_valid && out_ready;
	assign rd        = mem_q[rd_ptr_q];
	assign room      = cnt_q <= CntW'(Depth - 2);

	always_ff @(posedge clk) begin
		if (wr_cnt != 2'd0) mem_q[wr_ptr_q] <= wr0;
		if (wr_cnt == 2'd2) mem_q[wr_ptr1]  <= wr1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			case (wr_cnt)
				2'd1:    wr_ptr_q <= wr_ptr1;
				2'd2:    wr_ptr_q <= inc(wr_ptr1);
				default: wr_ptr_q <= wr_ptr_q;
			endcase
			if (pop) rd_ptr_q <= inc(rd_ptr_q);
			cnt_q <= cnt_q + CntW'(wr_cnt) - CntW'(pop);
		end
	end

endmodule

// ===== src/wav_stream_deframer_unit.sv =====
// Top level of the WAV stream deframer: input register, parser, result queue.
// Depends on wsd_pkg, wsd_parser and wsd_result_queue.
//
//   channel | direction | handshake            | payload
//   in      | in        | in_valid / in_ready   | stream_byte, end_of_stream
//   out     | out       | out_valid / out_ready | is_sample, pcm_sample, rate_hz, status, last_of_run
//   cfg     | in        | cfg_valid / cfg_ready | raw_mode
//
// One byte per cycle is taken while the result queue has room; the parser's single state
// update per byte sets that rate. A byte's results go from the input register into the
// result queue; the final byte adds a status result. A byte waits in the input register
// while the result queue has fewer than two free entries; the input stalls once that
// register is full. Reset clears all stream state at once; there is no clearing pass.
module wav_stream_deframer_unit #(
	parameter int unsigned QueueDepth = wsd_pkg::QUEUE_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         stream_byte,
	input  logic               end_of_stream,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               is_sample,
	output logic signed [16:0] pcm_sample,
	output logic [31:0]        rate_hz,
	output logic [1:0]         status,
	output logic               last_of_run,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic               raw_mode
);
	import wsd_pkg::*;

	logic       raw_q;
	logic       room;
	result_t    res0;
	result_t    res1;
	result_t    rd;
	logic [1:0] res_cnt;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			raw_q <= raw_mode;
		end
	end

	wsd_parser u_parser (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.stream_byte   (stream_byte),
		.end_of_stream (end_of_stream),
		.raw_mode      (raw_q),
		.room          (room),
		.res0          (res0),
		.res1          (res1),
		.res_cnt       (res_cnt)
	);

	wsd_result_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr0       (res0),
		.wr1       (res1),
		.wr_cnt    (res_cnt),
		.room      (room),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.rd        (rd)
	);

	assign is_sample   = rd.is_sample;
	assign pcm_sample  = rd.pcm_sample;
	assign rate_hz     = rd.rate_hz;
	assign status      = rd.status;
	assign last_of_run = rd.last_of_run;

endmodule

// ===== src/wsd_checker.sv =====
// Port-level checks for the WAV stream deframer, attached by bind.
// Depends on wsd_pkg for the status codes.
module wsd_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_ready,
	input logic               is_sample,
	input logic signed [16:0] pcm_sample,
	input logic [31:0]        rate_hz,
	input logic [1:0]         status,
	input logic               last_of_run
);
	import wsd_pkg::*;

	a_status_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !is_sample |-> last_of_run)
		else $error("status transfer without last_of_run");

	a_sample_status_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_sample |-> status == ST_OK)
		else $error("sample transfer with nonzero status");

	a_status_pcm_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !is_sample |-> pcm_sample == 17'sd0
			&& (status == ST_OK || status == ST_FORMAT || status == ST_TRUNC))
		else $error("bad status transfer payload");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(is_sample) && $stable(pcm_sample)
			&& $stable(rate_hz) && $stable(status) && $stable(last_of_run))
		else $error("result changed while stalled");

endmodule

bind wav_stream_deframer_unit wsd_checker u_wsd_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.is_sample   (is_sample),
	.pcm_sample  (pcm_sample),
	.rate_hz     (rate_hz),
	.status      (status),
	.last_of_run (last_of_run)
);

// ===== tb/tb_wav_stream_deframer_unit.sv =====
`timescale 1ns / 100ps
// Self-checking bench for wav_stream_deframer_unit: byte streams in, PCM results out.
// Needs wsd_pkg and the deframer RTL; it predicts every result and compares in order.
module tb_wav_stream_deframer_unit;
	import wsd_pkg::*;

	localparam logic [31:0] RIFF_TAG = "RIFF";
	localparam logic [31:0] WAVE_TAG = "WAVE";
	localparam logic [31:0] FMT_TAG = "fmt ";
	localparam logic [31:0] DATA_TAG = "data";
	localparam logic [31:0] LIST_TAG = "LIST";
	localparam int BODY_CAP = 96;
	localparam int RANDOM_BYTES = 600;
	localparam int PHASE_BYTES = 150;
	localparam int HOLD_CYCLES = 300;
	localparam int IDLE_PCT = 23;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic [7:0] b;
		logic       eos;
	} byte_item_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [7:0]         stream_byte = 8'h00;
	logic               end_of_stream = 1'b0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic               is_sample;
	logic signed [16:0] pcm_sample;
	logic [31:0]        rate_hz;
	logic [1:0]         status;
	logic               last_of_run;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic               cfg_raw = 1'b0;

	wav_stream_deframer_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.stream_byte(stream_byte),
		.end_of_stream(end_of_stream),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.is_sample(is_sample),
		.pcm_sample(pcm_sample),
		.rate_hz(rate_hz),
		.status(status),
		.last_of_run(last_of_run),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.raw_mode(cfg_raw)
	);

	always #1 clk = ~clk;

	// deframer state as seen from outside
	bit          mode_raw = 1'b0;
	logic [31:0] pos = '0;
	phase_t      phase = PH_HEADER;
	logic        hdr_ok = 1'b1;
	logic [15:0] chans = '0;
	logic [15:0] bits_per = '0;
	logic [31:0] rate_latch = '0;
	logic [63:0] chunk_hdr = '0;
	logic [32:0] remain = '0;
	logic [7:0]  lo_hold = '0;
	logic [15:0] left_hold = '0;
	logic [31:0] dsize_seen = '0;

	result_t    due_results[$];
	byte_item_t pending_bytes[$];
	logic [7:0] draft[$];
	byte_item_t next_item;
	result_t    want;
	result_t    got;

	int queued_bytes = 0;
	int accepted_bytes = 0;
	int mismatch_count = 0;
	int cycle_count = 0;
	int hold_left = 0;
	bit hold_done = 1'b0;
	bit hold_request = 1'b0;
	bit calm = 1'b0;

	function automatic bit fmt_ok();
		return hdr_ok && bits_per == 16'd16 && (chans == 16'd1 || chans == 16'd2);
	endfunction

	task automatic deframe_byte(input logic [7:0] b, input logic eos);
		logic [31:0]        rate_now;
		logic [31:0]        idx;
		logic [31:0]        lo;
		logic [31:0]        size;
		logic [15:0]        w;
		logic signed [16:0] val;
		logic [1:0]         st;
		bit                 have;
		int                 k;
		rate_now = mode_raw ? 32'd0 : rate_latch;
		have = 1'b0;
		val = '0;
		k = int'(pos[1:0]);
		if (mode_raw) begin
			if (pos[0]) begin
				have = 1'b1;
				val = {b, lo_hold, 1'b0};
			end else begin
				lo_hold = b;
			end
		end else begin
			case (phase)
				PH_HEADER: begin
					case (pos)
						32'd0, 32'd1, 32'd2, 32'd3: begin
							if (b != RIFF_TAG[31 - 8 * k -: 8]) hdr_ok = 1'b0;
						end
						32'd8, 32'd9, 32'd10, 32'd11: begin
							if (b != WAVE_TAG[31 - 8 * k -: 8]) hdr_ok = 1'b0;
						end
						32'd22: chans[7:0] = b;
						32'd23: chans[15:8] = b;
						32'd24, 32'd25, 32'd26, 32'd27: rate_latch[8 * k +: 8] = b;
						32'd34: bits_per[7:0] = b;
						32'd35: begin
							bits_per[15:8] = b;
							phase = PH_CHUNK;
							remain = '0;
						end
						default: ;
					endcase
				end
				PH_CHUNK: begin
					chunk_hdr = {chunk_hdr[55:0], b};
					remain = remain + 1;
					if (remain >= 8) begin
						lo = chunk_hdr[31:0];
						size = {lo[7:0], lo[15:8], lo[23:16], lo[31:24]};
						if (chunk_hdr[63:32] == DATA_TAG) begin
							dsize_seen = size;
							remain = {1'b0, size};
							phase = (size != 0) ? PH_DATA : PH_EMPTY;
						end else begin
							remain = {1'b0, size} + size[0];
							phase = (remain != 0) ? PH_SKIP : PH_CHUNK;
						end
					end
				end
				PH_SKIP: begin
					remain = remain - 1;
					if (remain == 0) phase = PH_CHUNK;
				end
				PH_DATA: begin
					idx = dsize_seen - remain[31:0];
					remain = remain - 1;
					if (remain == 0) phase = PH_DONE;
					if (!idx[0]) begin
						lo_hold = b;
					end else if (fmt_ok()) begin
						w = {b, lo_hold};
						if (chans == 16'd1) begin
							have = 1'b1;
							val = {w, 1'b0};
						end else if (idx[1:0] == 2'd1) begin
							left_hold = w;
						end else begin
							have = 1'b1;
							val = {left_hold[15], left_hold} + {w[15], w};
						end
					end
				end
				default: ;
			endcase
		end
		pos = pos + 1;
		if (have) due_results.push_back({1'b1, val, rate_now, ST_OK, ~eos});
		if (eos) begin
			if (mode_raw) st = ST_OK;
			else if (phase == PH_DONE && fmt_ok()) st = ST_OK;
			else if (phase == PH_DATA && fmt_ok()) st = ST_TRUNC;
			else st = ST_FORMAT;
			due_results.push_back({1'b0, 17'sd0, rate_now, st, 1'b1});
			pos = '0;
			phase = PH_HEADER;
			hdr_ok = 1'b1;
			chans = '0;
			bits_per = '0;
			rate_latch = '0;
			chunk_hdr = '0;
			remain = '0;
			lo_hold = '0;
			left_hold = '0;
			dsize_seen = '0;
		end
	endtask

	task automatic flag_error(input string msg);
		mismatch_count++;
		if (mismatch_count <= 10) $display("%s", msg);
	endtask

	task automatic put_le(input logic [63:0] v, input int n);
		for (int i = 0; i < n; i++) draft.push_back(v[8 * i +: 8]);
	endtask

	task automatic put_tag(input logic [31:0] t);
		for (int i = 0; i < 4; i++) draft.push_back(t[31 - 8 * i -: 8]);
	endtask

	task automatic put_noise(input int n);
		for (int i = 0; i < n; i++) draft.push_back(8'($urandom));
	endtask

	task automatic put_head(input logic [15:0] ch, input logic [15:0] bw,
			input logic [31:0] rate, input bit bad_riff, input bit bad_wave);
		logic [31:0] flip;
		flip = 32'h1 << (8 * $urandom_range(3) + $urandom_range(7));
		put_tag(bad_riff ? (RIFF_TAG ^ flip) : RIFF_TAG);
		put_le(64'($urandom), 4);
		put_tag(bad_wave ? (WAVE_TAG ^ flip) : WAVE_TAG);
		put_tag(FMT_TAG);
		put_le(64'd16, 4);
		put_le(64'd1, 2);
		put_le(64'(ch), 2);
		put_le(64'(rate), 4);
		put_le(64'($urandom), 4);
		put_le(64'($urandom), 2);
		put_le(64'(bw), 2);
	endtask

	task automatic put_chunk(input logic [31:0] tag, input logic [31:0] size);
		longint body;
		body = longint'(size) + size[0];
		put_tag(tag);
		put_le(64'(size), 4);
		put_noise(body > BODY_CAP ? BODY_CAP : int'(body));
	endtask

	task automatic put_data(input logic [31:0] size);
		put_tag(DATA_TAG);
		put_le(64'(size), 4);
	endtask

	task automatic send_draft(input int keep, input bit close);
		int n;
		n = (keep > 0 && keep < draft.size()) ? keep : draft.size();
		for (int i = 0; i < n; i++) pending_bytes.push_back({draft[i], close && i == n - 1});
		queued_bytes += n;
		draft.delete();
	endtask

	task automatic random_wav();
		logic [15:0] ch;
		logic [15:0] bw;
		logic [31:0] dsz;
		logic [23:0] tag_tail;
		int          pick;
		int          keep;
		if ($urandom_range(99) < 90) ch = 16'($urandom_range(1, 2));
		else if ($urandom_range(1) == 0) ch = $urandom_range(3) == 0 ? 16'd0 : 16'd3;
		else ch = 16'($urandom);
		if ($urandom_range(99) < 90) bw = 16'd16;
		else bw = $urandom_range(1) ? 16'd8 : 16'($urandom);
		put_head(ch, bw, $urandom, $urandom_range(99) < 5, $urandom_range(99) < 5);
		repeat ($urandom_range(2)) begin
			tag_tail = 24'($urandom);
			put_chunk({8'h4C, tag_tail}, $urandom_range(9));
		end
		pick = $urandom_range(99);
		if (pick >= 4) begin
			if (pick < 8) dsz = 32'd0;
			else if (pick < 12) dsz = $urandom;
			else dsz = $urandom_range(1, 48);
			put_data(dsz);
			put_noise(dsz > BODY_CAP ? BODY_CAP : int'(dsz));
			put_noise($urandom_range(3));
		end
		keep = ($urandom_range(99) < 12) ? $urandom_range(1, draft.size()) : 0;
		send_draft(keep, 1'b1);
	endtask

	task automatic settle();
		while (accepted_bytes != queued_bytes || due_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_mode(input bit v);
		settle();
		cfg_raw <= v;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		mode_raw = v;
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				deframe_byte(stream_byte, end_of_stream);
				accepted_bytes++;
			end
			if (!in_valid || in_ready) begin
				if (pending_bytes.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
					next_item = pending_bytes.pop_front();
					in_valid <= 1'b1;
					stream_byte <= next_item.b;
					end_of_stream <= next_item.eos;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (hold_request && !hold_done) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	always @(posedge clk) begin
		if (!arst_n) out_ready <= 1'b0;
		else out_ready <= (hold_left == 0) && (calm || $urandom_range(99) >= IDLE_PCT);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			got = {is_sample, pcm_sample, rate_hz, status, last_of_run};
			if (due_results.size() == 0) begin
				flag_error($sformatf("unexpected result: sample=%0b pcm=%0d rate=%0d status=%0d last=%0b",
					got.is_sample, got.pcm_sample, got.rate_hz, got.status, got.last_of_run));
			end else begin
				want = due_results.pop_front();
				if (got.is_sample !== want.is_sample || got.pcm_sample !== want.pcm_sample ||
						got.rate_hz !== want.rate_hz || got.status !== want.status ||
						got.last_of_run !== want.last_of_run) begin
					flag_error($sformatf({"result mismatch: expected sample=%0b pcm=%0d rate=%0d ",
						"status=%0d last=%0b, got sample=%0b pcm=%0d rate=%0d status=%0d last=%0b"},
						want.is_sample, want.pcm_sample, want.rate_hz, want.status,
						want.last_of_run, got.is_sample, got.pcm_sample, got.rate_hz,
						got.status, got.last_of_run));
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		int random_from;
		int phase_no;
		int phase_end;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		set_mode(1'b1);
		put_le(64'hFFFF_0000_7FFF_8000, 8);
		put_noise(1);
		send_draft(0, 1'b1);
		put_noise(1);
		send_draft(0, 1'b1);
		// leave a raw stream open across the mode change
		put_noise(3);
		send_draft(0, 1'b0);

		set_mode(1'b0);
		put_noise(5);
		send_draft(0, 1'b1);
		put_head(16'd1, 16'd16, 32'd44100, 1'b0, 1'b0);
		put_chunk(LIST_TAG, 32'd3);
		put_data(32'd9);
		put_le(64'hFFFF_0000_7FFF_8000, 8);
		put_noise(3);
		send_draft(0, 1'b1);
		put_head(16'd2, 16'd16, 32'd48000, 1'b0, 1'b0);
		put_data(32'd10);
		put_le(64'h7FFF_7FFF_8000_8000, 8);
		put_noise(2);
		send_draft(0, 1'b1);
		put_head(16'd1, 16'd16, 32'd0, 1'b1, 1'b0);
		put_data(32'd4);
		put_noise(4);
		send_draft(0, 1'b1);
		put_head(16'd2, 16'd16, $urandom, 1'b0, 1'b1);
		put_data(32'd4);
		put_noise(4);
		send_draft(0, 1'b1);
		put_head(16'd1, 16'd8, $urandom, 1'b0, 1'b0);
		put_data(32'd4);
		put_noise(4);
		send_draft(0, 1'b1);
		put_head(16'd3, 16'd16, $urandom, 1'b0, 1'b0);
		put_data(32'd4);
		put_noise(4);
		send_draft(0, 1'b1);
		put_head(16'd1, 16'd16, $urandom, 1'b0, 1'b0);
		put_data(32'd0);
		put_noise(3);
		send_draft(0, 1'b1);
		put_head(16'd2, 16'd16, $urandom, 1'b0, 1'b0);
		put_data(32'd32);
		put_noise(10);
		send_draft(0, 1'b1);
		put_head(16'd1, 16'd16, $urandom, 1'b0, 1'b0);
		send_draft(20, 1'b1);
		put_head(16'd1, 16'd16, $urandom, 1'b0, 1'b0);
		put_chunk(LIST_TAG, 32'd4);
		send_draft(0, 1'b1);
		put_head(16'd2, 16'd16, $urandom, 1'b0, 1'b0);
		put_chunk(LIST_TAG, 32'hFFFF_FFFF);
		send_draft(0, 1'b1);
		put_head(16'd1, 16'd16, 32'hFFFF_FFFF, 1'b0, 1'b0);
		put_data(32'hFFFF_FFFF);
		put_noise(6);
		send_draft(0, 1'b1);
		put_noise(1);
		send_draft(0, 1'b1);

		random_from = queued_bytes;
		phase_no = 0;
		while (phase_no < 3 || queued_bytes - random_from < RANDOM_BYTES) begin
			set_mode(phase_no % 3 == 1);
			calm = (phase_no == 2);
			hold_request = (phase_no == 1);
			phase_end = queued_bytes + PHASE_BYTES;
			while (queued_bytes < phase_end) begin
				if (mode_raw) begin
					put_noise($urandom_range(1, 64));
					send_draft(0, 1'b1);
				end else begin
					random_wav();
				end
			end
			if ($urandom_range(4) == 0) begin
				put_noise($urandom_range(1, 5));
				send_draft(0, 1'b0);
			end
			phase_no++;
		end

		settle();
		if (mismatch_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
